// ----- rtl/core/rau_pkg.sv -----
// Package for the rational arithmetic unit: item structs, action and status codes,
// and the sequencer state type. It depends on nothing else.
`default_nettype none

package rau_pkg;

   // Action codes carried by an input item.
   localparam logic [1:0] ACT_ADD  = 2'd0;
   localparam logic [1:0] ACT_MUL  = 2'd1;
   localparam logic [1:0] ACT_CMP  = 2'd2;
   localparam logic [1:0] ACT_NONE = 2'd3;

   // Status codes carried by a result item.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DEN = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] left_num;
      logic [30:0]        left_den;
      logic signed [31:0] right_num;
      logic [30:0]        right_den;
   } rau_req_type;

   typedef struct packed {
      logic signed [31:0] result_num;
      logic [30:0]        result_den;
      logic               is_less;
      logic               is_equal;
      logic [1:0]         status;
   } rau_rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_SUM,
      S_ABS,
      S_ALIGN,
      S_XODD,
      S_GCD,
      S_GSHIFT,
      S_DIV,
      S_CHECK,
      S_DONE
   } rau_state_type;

endpackage

`default_nettype wire

// ----- rtl/core/rational_arith_unit.sv -----
// Top level of the rational arithmetic unit: sequencer, shared multiplier, gcd and divider.
// Depends on rau_pkg for the item structs, codes and state type.
`default_nettype none

// Each item brings two fractions and an action (add, multiply or compare) and gives one
// result item. The block takes one item at a time: req_stall is high from acceptance until
// the result has moved into the output register, which then waits for the consumer while
// the next item is taken. A zero denominator or the unused action code goes straight to
// the result; a compare stops after the two cross products. Add and multiply use one 33 by 33 bit
// multiplier three times, then a binary gcd that makes one shift or one compare-and-subtract
// step per cycle over the 64-bit magnitudes (its number of steps is set by the bit lengths of
// the numerator and denominator, since every subtract is followed by at least one shift),
// then a shift-and-subtract divider that reduces numerator and denominator together. A sum
// or product of zero skips the gcd and the divider. WIDTH sets how many low bits of each
// field are taken and the range that a reduced result must fit.
module rational_arith_unit
   import rau_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire rau_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rau_rsp_type      rsp_data
);

   localparam int OPW = 33;
   localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

   rau_state_type state_ff, state_in;

   logic signed [OPW-1:0] ln_ff, ln_in, rn_ff, rn_in, ld_ff, ld_in, rd_ff, rd_in;
   logic [1:0]            act_ff, act_in;
   logic signed [63:0]    p0_ff, p0_in, p1_ff, p1_in;
   logic [63:0]           mag_ff, mag_in, den_ff, den_in;
   logic [63:0]           x_ff, x_in, y_ff, y_in;
   logic [63:0]           ra_ff, ra_in, rb_ff, rb_in;
   logic [5:0]            sh_ff, sh_in, cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   rau_rsp_type           res_ff, res_in;
   rau_rsp_type           rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  accept;
   logic                  zero_den;
   logic                  rsp_free;
   logic signed [OPW-1:0] mul_a, mul_b;
   logic signed [65:0]    prod;
   logic [64:0]           sub_yx, sub_xy;
   logic [64:0]           ta, tb;
   logic [64:0]           da, db;
   logic [63:0]           neg_mag;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign zero_den = (req_data.left_den[WIDTH-2:0] == '0) ||
                     (req_data.right_den[WIDTH-2:0] == '0);

   // Shared multiplier; the operand pair depends on the step.
   always_comb begin
      mul_a = ln_ff;
      mul_b = rd_ff;
      case (state_ff)
         S_MUL0: begin
            mul_a = ln_ff;
            mul_b = (act_ff == ACT_MUL) ? rn_ff : rd_ff;
         end
         S_MUL1: begin
            mul_a = rn_ff;
            mul_b = ld_ff;
         end
         S_MUL2: begin
            mul_a = ld_ff;
            mul_b = rd_ff;
         end
         default: begin
            mul_a = ln_ff;
            mul_b = rd_ff;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // Gcd step and divider lanes.
   assign sub_yx  = {1'b0, y_ff} - {1'b0, x_ff};
   assign sub_xy  = {1'b0, x_ff} - {1'b0, y_ff};
   assign ta      = {ra_ff, mag_ff[63]};
   assign tb      = {rb_ff, den_ff[63]};
   assign da      = ta - {1'b0, x_ff};
   assign db      = tb - {1'b0, x_ff};
   assign neg_mag = 64'd0 - mag_ff;

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.action == ACT_NONE || zero_den) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_MUL0;
               end
            end
         end
         S_MUL0: state_in = S_MUL1;
         S_MUL1: state_in = (act_ff == ACT_CMP) ? S_SUM : S_MUL2;
         S_MUL2: state_in = S_SUM;
         S_SUM:  state_in = (act_ff == ACT_CMP) ? S_DONE : S_ABS;
         S_ABS:  state_in = (mag_ff == '0) ? S_DONE : S_ALIGN;
         S_ALIGN: begin
            if (x_ff[0] || y_ff[0]) begin
               state_in = S_XODD;
            end
         end
         S_XODD: begin
            if (x_ff[0]) begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (y_ff[0] && (x_ff == y_ff)) begin
               state_in = S_GSHIFT;
            end
         end
         S_GSHIFT: state_in = S_DIV;
         S_DIV: begin
            if (cnt_ff == 6'd63) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath updates for each step.
   always_comb begin
      ln_in  = ln_ff;
      rn_in  = rn_ff;
      ld_in  = ld_ff;
      rd_in  = rd_ff;
      act_in = act_ff;
      p0_in  = p0_ff;
      p1_in  = p1_ff;
      mag_in = mag_ff;
      den_in = den_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      ra_in  = ra_ff;
      rb_in  = rb_ff;
      sh_in  = sh_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      res_in = res_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in = req_data.action;
               ln_in  = OPW'($signed(req_data.left_num[WIDTH-1:0]));
               rn_in  = OPW'($signed(req_data.right_num[WIDTH-1:0]));
               ld_in  = {{(OPW-WIDTH+1){1'b0}}, req_data.left_den[WIDTH-2:0]};
               rd_in  = {{(OPW-WIDTH+1){1'b0}}, req_data.right_den[WIDTH-2:0]};
               res_in.result_num = '0;
               res_in.result_den = 31'd1;
               res_in.is_less    = 1'b0;
               res_in.is_equal   = 1'b0;
               res_in.status     = STATUS_OK;
               if (req_data.action != ACT_NONE && zero_den) begin
                  res_in.status = STATUS_ZERO_DEN;
               end
            end
         end
         S_MUL0: p0_in = prod[63:0];
         S_MUL1: p1_in = prod[63:0];
         S_MUL2: den_in = prod[63:0];
         S_SUM: begin
            if (act_ff == ACT_CMP) begin
               res_in.is_less  = (p0_ff < p1_ff);
               res_in.is_equal = (p0_ff == p1_ff);
            end else if (act_ff == ACT_ADD) begin
               mag_in = 64'(p0_ff + p1_ff);
            end else begin
               mag_in = 64'(p0_ff);
            end
         end
         S_ABS: begin
            // Magnitude of the numerator; the sign is kept aside.
            neg_in = mag_ff[63];
            x_in   = mag_ff[63] ? neg_mag : mag_ff;
            mag_in = mag_ff[63] ? neg_mag : mag_ff;
            y_in   = den_ff;
            sh_in  = '0;
         end
         S_ALIGN: begin
            // Strip the common power of two.
            if (!x_ff[0] && !y_ff[0]) begin
               x_in  = x_ff >> 1;
               y_in  = y_ff >> 1;
               sh_in = sh_ff + 6'd1;
            end
         end
         S_XODD: begin
            if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end
         end
         S_GCD: begin
            // Either halve an even y, or keep the smaller and subtract.
            if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (sub_yx[64]) begin
               x_in = y_ff;
               y_in = sub_xy[63:0];
            end else begin
               y_in = sub_yx[63:0];
            end
         end
         S_GSHIFT: begin
            x_in   = x_ff << sh_ff;
            ra_in  = '0;
            rb_in  = '0;
            cnt_in = '0;
         end
         S_DIV: begin
            // One quotient bit for each lane; the gcd is the shared divisor.
            if (!da[64]) begin
               ra_in  = da[63:0];
               mag_in = {mag_ff[62:0], 1'b1};
            end else begin
               ra_in  = ta[63:0];
               mag_in = {mag_ff[62:0], 1'b0};
            end
            if (!db[64]) begin
               rb_in  = db[63:0];
               den_in = {den_ff[62:0], 1'b1};
            end else begin
               rb_in  = tb[63:0];
               den_in = {den_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
         end
         S_CHECK: begin
            if (den_ff > LIM - 64'd1 ||
                (neg_ff ? (mag_ff > LIM) : (mag_ff > LIM - 64'd1))) begin
               res_in.status = STATUS_OVERFLOW;
            end else begin
               res_in.result_num = neg_ff ? neg_mag[31:0] : mag_ff[31:0];
               res_in.result_den = den_ff[30:0];
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ln_ff  <= ln_in;
      rn_ff  <= rn_in;
      ld_ff  <= ld_in;
      rd_ff  <= rd_in;
      act_ff <= act_in;
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
      mag_ff <= mag_in;
      den_ff <= den_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      ra_ff  <= ra_in;
      rb_ff  <= rb_in;
      sh_ff  <= sh_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/rau_checker.sv -----
// Port checker for the rational arithmetic unit, with the bind that attaches it.
// Depends on rau_pkg and on the ports of rational_arith_unit.
`default_nettype none

module rau_checker
   import rau_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire rau_req_type req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire rau_rsp_type rsp_data
);

   // A result item that is held back keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held result item changed");

   // The unit works on one item at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while busy");

   // Any error status comes with the neutral fraction and no flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |->
         rsp_data.result_num == 32'sd0 && rsp_data.result_den == 31'd1 &&
         !rsp_data.is_less && !rsp_data.is_equal)
      else $error("error result not neutral");

   // Less and equal cannot both hold.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_less && rsp_data.is_equal))
      else $error("less and equal both set");

   // A reported fraction never has a zero denominator.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.result_den != 31'd0)
      else $error("zero denominator in result item");

endmodule

bind rational_arith_unit rau_checker u_rau_checker (.*);

`default_nettype wire
